[src/hte_pkg.sv]
package hte_pkg;

    localparam int unsigned RUN_W = 5;   // run length 1..24, position 0..23
    localparam int unsigned TXT_W = 192; // longest run, 24 characters

    typedef enum logic [3:0] {
        K_CHAR    = 4'd0,
        K_GT      = 4'd1,
        K_LT      = 4'd2,
        K_TAB     = 4'd3,
        K_QUOT    = 4'd4,
        K_APOS    = 4'd5,
        K_NBSP    = 4'd6,
        K_AMP     = 4'd7,
        K_NL_LF   = 4'd8,
        K_NL_CRLF = 4'd9,
        K_DEC     = 4'd10
    } kind_t;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;

    localparam logic [TXT_W-1:0] TXT_GT      = "&gt;";
    localparam logic [TXT_W-1:0] TXT_LT      = "&lt;";
    localparam logic [TXT_W-1:0] TXT_TAB     = "&nbsp;&nbsp;&nbsp;&nbsp;";
    localparam logic [TXT_W-1:0] TXT_QUOT    = "&quot;";
    localparam logic [TXT_W-1:0] TXT_APOS    = "&#39;";
    localparam logic [TXT_W-1:0] TXT_NBSP    = "&nbsp;";
    localparam logic [TXT_W-1:0] TXT_AMP     = "&amp;";
    localparam logic [TXT_W-1:0] TXT_NL_LF   = "<br/>\x0a";
    localparam logic [TXT_W-1:0] TXT_NL_CRLF = "<br/>\x0d\x0a";

    // One queued job: what to emit for one input byte.
    typedef struct packed {
        kind_t            kind;
        logic [7:0]       ch;
        logic [2:0][3:0]  dig;  // decimal digits, most significant in slot 2
        logic [RUN_W-1:0] len;
    } desc_t;

    // Fixed run lengths of the entity kinds.
    function automatic logic [RUN_W-1:0] kind_len(input kind_t kind);
        logic [RUN_W-1:0] n;
        case (kind)
            K_GT, K_LT:    n = RUN_W'(4);
            K_TAB:         n = RUN_W'(24);
            K_QUOT:        n = RUN_W'(6);
            K_APOS, K_AMP: n = RUN_W'(5);
            K_NBSP:        n = RUN_W'(6);
            K_NL_LF:       n = RUN_W'(6);
            K_NL_CRLF:     n = RUN_W'(7);
            default:       n = RUN_W'(1);
        endcase
        return n;
    endfunction

    // Character at pos of a right-aligned string literal of length len.
    function automatic logic [7:0] str_at(input logic [TXT_W-1:0] s,
                                          input logic [RUN_W-1:0] len,
                                          input logic [RUN_W-1:0] pos);
        logic [RUN_W-1:0] idx;
        idx = RUN_W'(len - pos - RUN_W'(1));
        return s[{idx, 3'b000} +: 8];
    endfunction

endpackage

[src/hte_front.sv]
module hte_front
    import hte_pkg::*;
(
    input  logic [7:0] in_byte,
    input  logic       crlf,
    output logic       keep,
    output desc_t      desc
);

    logic [1:0]  hun;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  ten;
    logic [3:0]  one;

    // Split into decimal digits: compare for hundreds, reciprocal for tens.
    always_comb
    begin
        if (in_byte >= 8'd200)
            hun = 2'd2;
        else if (in_byte >= 8'd100)
            hun = 2'd1;
        else
            hun = 2'd0;
        rem  = 7'(in_byte - ((hun == 2'd2) ? 8'd200 : (hun == 2'd1) ? 8'd100 : 8'd0));
        prod = 15'(rem) * 15'd205;
        ten  = 4'(prod >> 11);
        one  = 4'(rem - 7'(ten) * 7'd10);
    end

    always_comb
    begin
        keep      = 1'b1;
        desc.ch   = in_byte;
        desc.dig  = '0;
        desc.kind = K_CHAR;
        if (in_byte == CH_CR)
            keep = 1'b0;
        else if (in_byte == CH_LF)
            desc.kind = crlf ? K_NL_CRLF : K_NL_LF;
        else if (in_byte == CH_GT)
            desc.kind = K_GT;
        else if (in_byte == CH_LT)
            desc.kind = K_LT;
        else if (in_byte == CH_TAB)
            desc.kind = K_TAB;
        else if (in_byte == CH_QUOT)
            desc.kind = K_QUOT;
        else if (in_byte == CH_APOS)
            desc.kind = K_APOS;
        else if (in_byte == CH_SPACE)
            desc.kind = K_NBSP;
        else if (in_byte == CH_AMP)
            desc.kind = K_AMP;
        else if (in_byte < 8'd32 || in_byte >= 8'd128)
            desc.kind = K_DEC;

        if (in_byte >= 8'd100)
            desc.dig = {hun == 2'd2 ? 4'd2 : 4'd1, ten, one};
        else if (in_byte >= 8'd10)
            desc.dig = {ten, one, 4'd0};
        else
            desc.dig = {one, 4'd0, 4'd0};

        // &# digits ;
        if (desc.kind == K_DEC)
        begin
            if (in_byte >= 8'd100)
                desc.len = RUN_W'(6);
            else if (in_byte >= 8'd10)
                desc.len = RUN_W'(5);
            else
                desc.len = RUN_W'(4);
        end
        else
        begin
            desc.len = kind_len(desc.kind);
        end
    end

endmodule

[src/hte_queue.sv]
module hte_queue
    import hte_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output desc_t head,
    output logic  empty,
    output logic  full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    desc_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        if (push && !pop)
            count_next = CNT_W'(count_reg + 1'b1);
        else if (pop && !push)
            count_next = CNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_desc;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

endmodule

[src/hte_back.sv]
module hte_back
    import hte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  desc_t      head,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic [RUN_W-1:0] pos_reg, pos_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             load;
    logic             at_end;
    logic [7:0]       cur_byte;
    logic [1:0]       dig_idx;

    assign load   = !valid_reg || out_ready;
    assign at_end = (pos_reg == RUN_W'(head.len - RUN_W'(1)));
    assign pop    = load && !empty && at_end;
    assign dig_idx = 2'(pos_reg - RUN_W'(2));

    always_comb
    begin
        case (head.kind)
            K_CHAR:    cur_byte = head.ch;
            K_GT:      cur_byte = str_at(TXT_GT, head.len, pos_reg);
            K_LT:      cur_byte = str_at(TXT_LT, head.len, pos_reg);
            K_TAB:     cur_byte = str_at(TXT_TAB, head.len, pos_reg);
            K_QUOT:    cur_byte = str_at(TXT_QUOT, head.len, pos_reg);
            K_APOS:    cur_byte = str_at(TXT_APOS, head.len, pos_reg);
            K_NBSP:    cur_byte = str_at(TXT_NBSP, head.len, pos_reg);
            K_AMP:     cur_byte = str_at(TXT_AMP, head.len, pos_reg);
            K_NL_LF:   cur_byte = str_at(TXT_NL_LF, head.len, pos_reg);
            K_NL_CRLF: cur_byte = str_at(TXT_NL_CRLF, head.len, pos_reg);
            K_DEC:
            begin
                if (pos_reg == '0)
                    cur_byte = CH_AMP;
                else if (pos_reg == RUN_W'(1))
                    cur_byte = CH_HASH;
                else if (at_end)
                    cur_byte = CH_SEMI;
                else
                    cur_byte = CH_ZERO + 8'(head.dig[2'd2 - dig_idx]);
            end
            default:   cur_byte = head.ch;
        endcase
    end

    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = !empty;
            byte_next  = cur_byte;
            last_next  = at_end;
            // advance through the run, rewind on its last word
            if (!empty)
                pos_next = at_end ? '0 : RUN_W'(pos_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> pos_reg == '0)
        else $error("run position not rewound while queue empty");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pos_reg < head.len)
        else $error("run position past run length");

endmodule

[src/html_text_escaper.sv]
// Kept bytes pass the descriptor queue, then the output register. Throughput: one
// output word per cycle while m_tready is high; an input byte occupies the output for
// its run length (1 to 24 words, none for CR), set by the single-word output register.
// Input is taken every cycle while the descriptor queue (QUEUE_DEPTH entries) has room.
// Reset (rst_n low, async): queue and output emptied, crlf_line_end cleared to 0.
module html_text_escaper
    import hte_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data   // crlf_line_end
);

    logic  crlf_reg;
    logic  keep;
    desc_t front_desc;
    desc_t head;
    logic  push;
    logic  pop;
    logic  empty;
    logic  full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crlf_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            crlf_reg <= cfg_data;
    end

    assign s_tready = !full;
    assign push     = s_tvalid && s_tready && keep;

    hte_front u_front (
        .in_byte (s_tdata),
        .crlf    (crlf_reg),
        .keep    (keep),
        .desc    (front_desc)
    );

    hte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (front_desc),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    hte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
